@@ rtl/causal_tile_partial_sum_reduce_top_macros.svh @@
// Assertion macros used by the reducer RTL (ctpsr_back).
`ifndef CAUSAL_TILE_PARTIAL_SUM_REDUCE_TOP_MACROS_SVH
`define CAUSAL_TILE_PARTIAL_SUM_REDUCE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define CTPSR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication.
`define CTPSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CTPSR_ASSERT_NOW(label, clk, rst, ante, cons)
`define CTPSR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/ctpsr_pkg.sv @@
package ctpsr_pkg;

   localparam int TILE_ROWS_DEFAULT = 64;
   localparam int LANES = 4;

   localparam logic [0:0] CSR_KEY_TILE_COUNT = 1'b0;
   localparam logic [0:0] CSR_CAUSAL_ENABLE  = 1'b1;

   typedef struct packed {
      logic                   clear;
      logic                   emit;
      logic [15:0]            row;
      logic [LANES-1:0][31:0] lanes;
   } work_type;

   function automatic logic [31:0] half_to_single(input logic [15:0] h);
      logic [4:0]  ex;
      logic [9:0]  man;
      logic [9:0]  nm;
      logic [7:0]  e32;
      logic [3:0]  lz;
      logic        found;
      logic [31:0] res;
      ex    = h[14:10];
      man   = h[9:0];
      lz    = '0;
      found = 1'b0;
      nm    = '0;
      e32   = '0;
      if (ex == 5'h1F) begin
         res = {h[15], 8'hFF, man, 13'b0};
      end else if (ex == 5'h00) begin
         if (man == 10'h0) begin
            res = {h[15], 31'b0};
         end else begin
            for (int i = 9; i >= 0; i--) begin
               if (!found && man[i]) begin
                  found = 1'b1;
                  lz    = 4'(9 - i);
               end
            end
            nm  = man << (lz + 4'd1);
            e32 = 8'd112 - {4'b0, lz};
            res = {h[15], e32, nm, 13'b0};
         end
      end else begin
         e32 = {3'b0, ex} + 8'd112;
         res = {h[15], e32, man, 13'b0};
      end
      return res;
   endfunction

   function automatic logic [15:0] single_to_half(input logic [31:0] b);
      logic        s;
      logic [7:0]  ex;
      logic [22:0] man;
      logic [23:0] full;
      logic [4:0]  shift;
      logic [15:0] r;
      logic [23:0] rem;
      logic [23:0] half;
      logic [15:0] res;
      s     = b[31];
      ex    = b[30:23];
      man   = b[22:0];
      full  = {1'b1, man};
      shift = '0;
      r     = '0;
      rem   = '0;
      half  = '0;
      res   = '0;
      if (ex == 8'hFF) begin
         res = (man != 23'h0) ? 16'h7E00 : {s, 15'h7C00};
      end else if (ex >= 8'd143) begin
         res = {s, 15'h7C00};
      end else if (ex < 8'd102) begin
         res = {s, 15'h0};
      end else begin
         if (ex <= 8'd112) begin
            shift = 5'(8'd126 - ex);
            r     = 16'(full >> shift);
            rem   = full & ((24'd1 << shift) - 24'd1);
            half  = 24'd1 << (shift - 5'd1);
         end else begin
            r    = {1'b0, 5'(ex - 8'd112), man[22:13]};
            rem  = {11'b0, man[12:0]};
            half = 24'h1000;
         end
         if (rem > half || (rem == half && r[0]))
            r = r + 16'd1;
         res = {s, 15'h0} | r;
      end
      return res;
   endfunction

   // Binary32 add, round to nearest even, subnormals kept.
   function automatic logic [31:0] fp32_add(input logic [31:0] a, input logic [31:0] b);
      logic        a_nan, b_nan, a_inf, b_inf;
      logic        swap;
      logic [31:0] big, lesser;
      logic [7:0]  e_big, e_small, d, e_n, sh;
      logic [23:0] m_big, m_small;
      logic [26:0] small_ext, small_al;
      logic        sticky;
      logic [27:0] s;
      logic [26:0] s_n;
      logic [4:0]  lz;
      logic [7:0]  field;
      logic        rnd;
      logic [30:0] packed_res;
      logic [31:0] res;
      a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'h0);
      b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'h0);
      a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'h0);
      b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'h0);
      swap   = b[30:0] > a[30:0];
      big    = swap ? b : a;
      lesser = swap ? a : b;
      e_big   = (big[30:23] == 8'h0) ? 8'd1 : big[30:23];
      e_small = (lesser[30:23] == 8'h0) ? 8'd1 : lesser[30:23];
      m_big   = {big[30:23] != 8'h0, big[22:0]};
      m_small = {lesser[30:23] != 8'h0, lesser[22:0]};
      d = e_big - e_small;
      small_ext = {m_small, 3'b0};
      sticky    = 1'b0;
      if (d >= 8'd27) begin
         small_al = {26'b0, m_small != 24'h0};
      end else begin
         small_al = small_ext >> d;
         sticky   = |(small_ext & 27'((28'd1 << d) - 28'd1));
         small_al[0] = small_al[0] | sticky;
      end
      if (a[31] == b[31])
         s = {1'b0, m_big, 3'b0} + {1'b0, small_al};
      else
         s = {1'b0, m_big, 3'b0} - {1'b0, small_al};
      lz  = '0;
      for (int i = 0; i < 27; i++) begin
         if (s[i])
            lz = 5'(26 - i);
      end
      if (s[27]) begin
         s_n = {s[27:2], s[1] | s[0]};
         e_n = e_big + 8'd1;
      end else begin
         sh  = ({3'b0, lz} < (e_big - 8'd1)) ? {3'b0, lz} : (e_big - 8'd1);
         s_n = s[26:0] << sh;
         e_n = e_big - sh;
      end
      field = s_n[26] ? e_n : 8'h0;
      rnd   = s_n[2] && (s_n[1] || s_n[0] || s_n[3]);
      packed_res = {field, s_n[25:3]} + 31'(rnd);
      if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31])))
         res = 32'h7FC00000;
      else if (a_inf)
         res = a;
      else if (b_inf)
         res = b;
      else if (s == 28'h0)
         res = {a[31] & b[31], 31'h0};
      else if (e_n == 8'hFF)
         res = {big[31], 31'h7F800000};
      else
         res = {big[31], packed_res};
      return res;
   endfunction

endpackage

@@ rtl/ctpsr_front.sv @@
module ctpsr_front #(
   parameter int TILE_ROWS = ctpsr_pkg::TILE_ROWS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [95:0]          req_tdata,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [0:0]           csr_index,
   input  logic [10:0]          csr_data,
   output logic                 push,
   output ctpsr_pkg::work_type  push_entry,
   input  logic                 q_ready
);
   import ctpsr_pkg::*;

   logic [10:0] key_tile_count_ff, key_tile_count_in;
   logic        causal_enable_ff, causal_enable_in;
   logic [15:0] row_index;
   logic [9:0]  tile_index;
   logic [10:0] last_tile;
   logic [19:0] tile_base;
   logic        beyond;
   logic        at_last;

   assign csr_ready = 1'b1;

   always_comb begin
      key_tile_count_in = key_tile_count_ff;
      causal_enable_in  = causal_enable_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_KEY_TILE_COUNT: key_tile_count_in = csr_data;
            CSR_CAUSAL_ENABLE:  causal_enable_in  = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_tile_count_ff <= 11'd1;
         causal_enable_ff  <= 1'b0;
      end else begin
         key_tile_count_ff <= key_tile_count_in;
         causal_enable_ff  <= causal_enable_in;
      end
   end

   assign row_index  = req_tdata[15:0];
   assign tile_index = req_tdata[25:16];
   assign last_tile  = key_tile_count_ff - 11'd1;

   // In causal mode the row's last tile is row / TILE_ROWS; comparing the row
   // against tile * TILE_ROWS avoids the division.
   assign tile_base = 20'(tile_index) * 20'(TILE_ROWS);

   always_comb begin
      if (causal_enable_ff) begin
         beyond  = 20'(row_index) < tile_base;
         at_last = !beyond && (20'(row_index) < tile_base + 20'(TILE_ROWS));
      end else begin
         beyond  = {1'b0, tile_index} > last_tile;
         at_last = {1'b0, tile_index} == last_tile;
      end
   end

   assign req_tready = q_ready;
   assign push       = req_tvalid && q_ready && !beyond;

   always_comb begin
      push_entry.clear = tile_index == 10'd0;
      push_entry.emit  = at_last;
      push_entry.row   = row_index;
      for (int i = 0; i < LANES; i++)
         push_entry.lanes[i] = half_to_single(req_tdata[26 + 16*i +: 16]);
   end

endmodule

@@ rtl/ctpsr_queue.sv @@
module ctpsr_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ctpsr_pkg::work_type  push_entry,
   output logic                 q_ready,
   output logic                 q_valid,
   output ctpsr_pkg::work_type  q_entry,
   input  logic                 pop
);
   import ctpsr_pkg::*;

   work_type    mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign q_ready = count_ff != 2'd2;
   assign q_valid = count_ff != 2'd0;
   assign q_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

@@ rtl/ctpsr_back.sv @@
`include "causal_tile_partial_sum_reduce_top_macros.svh"
module ctpsr_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  ctpsr_pkg::work_type  q_entry,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [79:0]          rsp_tdata
);
   import ctpsr_pkg::*;

   logic [LANES-1:0][31:0] acc_ff, acc_in;
   logic                   pend_ff, pend_in;
   logic [15:0]            pend_row_ff, pend_row_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [79:0]            rsp_data_ff, rsp_data_in;
   logic                   rsp_adv;
   logic                   pend_ok;

   // The accumulators must hold while a finished sum waits for the output.
   assign rsp_adv = !rsp_valid_ff || rsp_tready;
   assign pend_ok = !pend_ff || rsp_adv;
   assign pop     = q_valid && pend_ok;

   always_comb begin
      acc_in = acc_ff;
      if (pop) begin
         for (int i = 0; i < LANES; i++)
            acc_in[i] = fp32_add(q_entry.clear ? 32'h0 : acc_ff[i], q_entry.lanes[i]);
      end
   end

   always_comb begin
      pend_row_in = pend_row_ff;
      if (pop) begin
         pend_in     = q_entry.emit;
         pend_row_in = q_entry.row;
      end else begin
         pend_in = pend_ff && !rsp_adv;
      end
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (pend_ff && rsp_adv) begin
         rsp_valid_in = 1'b1;
         rsp_data_in[15:0] = pend_row_ff;
         for (int i = 0; i < LANES; i++)
            rsp_data_in[16 + 16*i +: 16] = single_to_half(acc_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_row_ff <= pend_row_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `CTPSR_ASSERT_NOW(no_pop_when_blocked, clock, reset,
      pend_ff && rsp_valid_ff && !rsp_tready, !pop)
   `CTPSR_ASSERT_NEXT(emit_sets_pending, clock, reset, pop && q_entry.emit, pend_ff)
   `CTPSR_ASSERT_NEXT(pending_reaches_output, clock, reset, pend_ff && rsp_adv, rsp_valid_ff)

endmodule

@@ rtl/causal_tile_partial_sum_reduce_top.sv @@
// Split-K reducer: each request carries a row, a key-tile number and four
// fp16 partials; lanes are widened to fp32 and summed in arrival order, tile 0
// restarting the sums, and at the row's last tile (row / TILE_ROWS when causal,
// else key_tile_count - 1) the four sums are rounded to fp16 and sent as one
// response. Tiles past the last are dropped. One request is taken every cycle
// while the queue has room; the rate is set by the combinational fp32 adder
// in each lane's accumulator loop. A two-entry queue between the classifier
// and the accumulators absorbs stalls.
module causal_tile_partial_sum_reduce_top #(
   parameter int TILE_ROWS = ctpsr_pkg::TILE_ROWS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // row_index, tile_index, lane0_half, lane1_half, lane2_half, lane3_half, zero pad
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_row, sum0_half, sum1_half, sum2_half, sum3_half
   output logic [79:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [10:0] csr_data
);
   import ctpsr_pkg::*;

   logic     push;
   work_type push_entry;
   logic     q_ready;
   logic     q_valid;
   work_type q_entry;
   logic     pop;

   ctpsr_front #(.TILE_ROWS(TILE_ROWS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .push       (push),
      .push_entry (push_entry),
      .q_ready    (q_ready)
   );

   ctpsr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .q_ready    (q_ready),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .pop        (pop)
   );

   ctpsr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ tb/tb_causal_tile_partial_sum_reduce_top.sv @@
module tb_causal_tile_partial_sum_reduce_top;
   import ctpsr_pkg::*;

   localparam int TILE_ROWS = 64;

   // Members are listed from the highest bits down, so row lands in the lowest bits.
   typedef struct packed {
      logic [3:0][15:0] lane;
      logic [9:0]       tile;
      logic [15:0]      row;
   } partial_type;

   typedef struct packed {
      logic [3:0][15:0] sum;
      logic [15:0]      row;
   } reduced_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = CSR_KEY_TILE_COUNT;
   logic [10:0] csr_data = '0;

   causal_tile_partial_sum_reduce_top #(.TILE_ROWS(TILE_ROWS)) i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   partial_type pending_q[$];
   reduced_type reduced_q[$];
   logic [31:0] acc_sum[4];
   logic [10:0] tile_count_reg;
   logic        causal_reg;
   int          idle_mode;
   int          errors;
   logic        req_fire;

   function automatic logic [31:0] widen_half(input logic [15:0] h);
      logic [10:0] m;
      logic [7:0]  e;
      m = {1'b0, h[9:0]};
      e = 8'd113;
      if (h[14:10] == 5'h1F)
         return {h[15], 8'hFF, h[9:0], 13'b0};
      if (h[14:10] != 5'h0)
         return {h[15], 8'({3'b0, h[14:10]} + 8'd112), h[9:0], 13'b0};
      if (m == 11'h0)
         return {h[15], 31'b0};
      for (int i = 0; i < 11; i++) begin
         if (!m[10]) begin
            m = m << 1;
            e = e - 8'd1;
         end
      end
      return {h[15], e, m[9:0], 13'b0};
   endfunction

   function automatic logic [15:0] narrow_single(input logic [31:0] b);
      int          e;
      int          sh;
      logic [23:0] m;
      logic [23:0] r;
      logic [23:0] rem;
      logic [23:0] hf;
      m = {1'b1, b[22:0]};
      e = int'(b[30:23]) - 112;
      if (b[30:23] == 8'hFF)
         return (b[22:0] != 0) ? 16'h7E00 : {b[31], 15'h7C00};
      if (e >= 31)
         return {b[31], 15'h7C00};
      if (e >= 1) begin
         r   = {9'b0, 5'(e), b[22:13]};
         rem = {11'b0, b[12:0]};
         hf  = 24'h1000;
      end else begin
         sh = 14 - e;
         if (b[30:23] == 8'h0 || sh > 24)
            return {b[31], 15'h0};
         r   = m >> sh;
         rem = m & ((24'd1 << sh) - 24'd1);
         hf  = 24'd1 << (sh - 1);
      end
      if (rem > hf || (rem == hf && r[0]))
         r = r + 24'd1;
      return {b[31], 15'h0} | r[15:0];
   endfunction

   // Exact sum in a wide integer, then one rounding to binary32.
   function automatic logic [31:0] add_single(input logic [31:0] a, input logic [31:0] b);
      logic [31:0]  x;
      logic [31:0]  y;
      int           ex;
      int           ey;
      int           d;
      int           p;
      int           e;
      int           sh;
      logic [127:0] wa;
      logic [127:0] wb;
      logic [127:0] s;
      logic [127:0] q;
      logic [127:0] rem;
      logic [127:0] hf;
      if ((a[30:23] == 8'hFF && a[22:0] != 0) || (b[30:23] == 8'hFF && b[22:0] != 0))
         return 32'h7FC00000;
      if (a[30:23] == 8'hFF && b[30:23] == 8'hFF && a[31] != b[31])
         return 32'h7FC00000;
      if (a[30:23] == 8'hFF)
         return a;
      if (b[30:23] == 8'hFF)
         return b;
      if (a[30:0] >= b[30:0]) begin
         x = a;
         y = b;
      end else begin
         x = b;
         y = a;
      end
      ex = (x[30:23] == 0) ? 1 : int'(x[30:23]);
      ey = (y[30:23] == 0) ? 1 : int'(y[30:23]);
      d  = ex - ey;
      wa = {104'b0, (x[30:23] != 0), x[22:0]} << 100;
      if (d > 100)
         wb = {127'b0, (y[30:0] != 0)};
      else
         wb = ({104'b0, (y[30:23] != 0), y[22:0]} << 100) >> d;
      s = (a[31] == b[31]) ? wa + wb : wa - wb;
      if (s == 0)
         return {a[31] & b[31], 31'b0};
      p = 0;
      for (int i = 0; i < 128; i++)
         if (s[i])
            p = i;
      e = ex + p - 123;
      if (e < 1) begin
         e  = 1;
         sh = 101 - ex;
      end else begin
         sh = p - 23;
      end
      q   = s >> sh;
      rem = s & ((128'd1 << sh) - 128'd1);
      hf  = 128'd1 << (sh - 1);
      if (rem > hf || (rem == hf && q[0]))
         q = q + 128'd1;
      if (q[24]) begin
         q = q >> 1;
         e = e + 1;
      end
      if (e >= 255)
         return {x[31], 8'hFF, 23'b0};
      return {x[31], q[23] ? 8'(e) : 8'd0, q[22:0]};
   endfunction

   function automatic void reduce_partial(input partial_type it);
      logic [10:0] last;
      reduced_type r;
      last = causal_reg ? 11'(it.row / TILE_ROWS) : 11'(tile_count_reg - 11'd1);
      if ({1'b0, it.tile} > last)
         return;
      for (int i = 0; i < 4; i++) begin
         if (it.tile == 0)
            acc_sum[i] = 32'h0;
         acc_sum[i] = add_single(acc_sum[i], widen_half(it.lane[i]));
      end
      if ({1'b0, it.tile} == last) begin
         r.row = it.row;
         for (int i = 0; i < 4; i++)
            r.sum[i] = narrow_single(acc_sum[i]);
         reduced_q.push_back(r);
      end
   endfunction

   always @(posedge clock) begin
      reduced_type got;
      reduced_type want;
      req_fire <= req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready)
            reduce_partial(req_tdata[89:0]);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (reduced_q.size() == 0) begin
               $display("%0t: unexpected response: expected none, actual %h", $time, got);
               errors++;
            end else begin
               want = reduced_q.pop_front();
               if (got.row != want.row) begin
                  $display("%0t: out_row: expected %h, actual %h", $time, want.row, got.row);
                  errors++;
               end
               for (int i = 0; i < 4; i++)
                  if (got.sum[i] != want.sum[i]) begin
                     $display("%0t: sum%0d_half: expected %h, actual %h", $time, i,
                              want.sum[i], got.sum[i]);
                     errors++;
                  end
            end
         end
      end
   end

   function automatic logic gap_roll(input int mode_a);
      if (idle_mode == mode_a)
         return ($urandom_range(99) < 46);
      if (idle_mode == 3)
         return ($urandom_range(99) < 24);
      return 1'b0;
   endfunction

   always @(negedge clock) begin
      logic        v;
      logic [95:0] dat;
      v   = req_tvalid;
      dat = req_tdata;
      if (!reset) begin
         if (!req_tvalid || req_fire) begin
            v = 1'b0;
            if (pending_q.size() > 0 && !gap_roll(1)) begin
               dat = {6'b0, pending_q.pop_front()};
               v   = 1'b1;
            end
         end
         rsp_tready <= !gap_roll(2);
      end
      req_tvalid <= v;
      req_tdata  <= dat;
   end

   task automatic write_csr(input logic [0:0] idx, input logic [10:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_KEY_TILE_COUNT)
         tile_count_reg = val;
      else
         causal_reg = val[0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Sender stays quiet until the block has drained, then the pipeline settles.
   task automatic drain();
      while (pending_q.size() > 0 || req_tvalid || reduced_q.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_half();
      case ($urandom_range(4))
         0: return 16'($urandom);
         1: return {1'($urandom), 5'($urandom_range(2)), 10'($urandom)};
         2: return {1'($urandom), 5'($urandom_range(12, 18)), 10'($urandom)};
         3: return {1'($urandom), 5'($urandom_range(28, 30)), 10'($urandom)};
         default: begin
            case ($urandom_range(3))
               0: return 16'h7C00;
               1: return 16'hFC00;
               2: return 16'h7E01;
               default: return 16'h8000;
            endcase
         end
      endcase
   endfunction

   task automatic push_partial(input logic [15:0] row, input logic [9:0] tile);
      partial_type it;
      it.row  = row;
      it.tile = tile;
      for (int i = 0; i < 4; i++)
         it.lane[i] = rand_half();
      pending_q.push_back(it);
   endtask

   task automatic push_fixed(input logic [15:0] row, input logic [9:0] tile,
                             input logic [15:0] v);
      partial_type it;
      it.row  = row;
      it.tile = tile;
      for (int i = 0; i < 4; i++)
         it.lane[i] = v ^ (16'(i) & 16'h8000);
      pending_q.push_back(it);
   endtask

   task automatic random_phase(input int count);
      int          sent;
      int          last;
      logic [15:0] row;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 85) begin
            if (causal_reg) begin
               row = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(383));
               last = row / TILE_ROWS;
            end else begin
               row = 16'($urandom);
               last = int'(tile_count_reg) - 1;
               if (last < 0)
                  last = 2047;
            end
            if (last > 1023) begin
               for (int t = 0; t < 4; t++)
                  push_partial(row, 10'($urandom));
               sent += 4;
            end else if (last > 12) begin
               for (int t = 0; t < 4; t++)
                  push_partial(row, 10'(t));
               push_partial(row, 10'(last));
               sent += 5;
            end else begin
               for (int t = 0; t <= last; t++)
                  push_partial(row, 10'(t));
               sent += last + 1;
            end
         end else begin
            push_partial(16'($urandom), 10'($urandom));
            sent++;
         end
      end
      drain();
   endtask

   initial begin
      errors         = 0;
      idle_mode      = 0;
      tile_count_reg = 11'd1;
      causal_reg     = 1'b0;
      for (int i = 0; i < 4; i++)
         acc_sum[i] = 32'h0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Single-tile rows: every lane pattern class, and tiles past the last.
      push_fixed(16'h0000, 10'd0, 16'h0000);
      push_fixed(16'hFFFF, 10'd0, 16'h8000);
      push_fixed(16'h1234, 10'd0, 16'h7C00);
      push_fixed(16'h0001, 10'd0, 16'h7E00);
      push_fixed(16'h0002, 10'd0, 16'h7C01);
      push_fixed(16'h0003, 10'd0, 16'h0001);
      push_fixed(16'h0004, 10'd0, 16'h03FF);
      push_fixed(16'h0005, 10'd0, 16'hFBFF);
      push_fixed(16'h0006, 10'd1023, 16'h3C00);
      push_fixed(16'h0007, 10'd5, 16'h3C00);
      drain();

      // Three tiles: overflow to infinity, cancellation, repeated last tile, inf minus inf.
      write_csr(CSR_KEY_TILE_COUNT, 11'd3);
      write_csr(CSR_CAUSAL_ENABLE, 11'd0);
      for (int t = 0; t < 3; t++)
         push_fixed(16'h0010, 10'(t), 16'h7BFF);
      push_fixed(16'h0011, 10'd0, 16'h3C00);
      push_fixed(16'h0011, 10'd1, 16'hBC00);
      push_fixed(16'h0011, 10'd2, 16'h0001);
      push_fixed(16'h0011, 10'd2, 16'h0001);
      push_fixed(16'h0012, 10'd0, 16'h7C00);
      push_fixed(16'h0012, 10'd1, 16'hFC00);
      push_fixed(16'h0012, 10'd2, 16'h0000);
      drain();

      write_csr(CSR_KEY_TILE_COUNT, 11'd1024);
      push_fixed(16'hAAAA, 10'd0, 16'h5555);
      push_fixed(16'hAAAA, 10'd1023, 16'h3C00);
      drain();
      write_csr(CSR_KEY_TILE_COUNT, 11'd0);
      push_fixed(16'h0020, 10'd0, 16'h3C00);
      push_fixed(16'h0020, 10'd1023, 16'h3C00);
      drain();

      write_csr(CSR_CAUSAL_ENABLE, 11'd1);
      push_fixed(16'h0000, 10'd0, 16'h4000);
      push_fixed(16'hFFFF, 10'd0, 16'h4000);
      push_fixed(16'hFFFF, 10'd1023, 16'h4000);
      drain();

      for (int ph = 0; ph < 10; ph++) begin
         idle_mode = ph % 4;
         case (ph)
            0: write_csr(CSR_KEY_TILE_COUNT, 11'd1);
            1: write_csr(CSR_KEY_TILE_COUNT, 11'd4);
            2: write_csr(CSR_KEY_TILE_COUNT, 11'd7);
            3: write_csr(CSR_KEY_TILE_COUNT, 11'd1024);
            4: write_csr(CSR_KEY_TILE_COUNT, 11'd2);
            5: write_csr(CSR_KEY_TILE_COUNT, 11'd2047);
            default: write_csr(CSR_KEY_TILE_COUNT, 11'($urandom_range(1, 12)));
         endcase
         write_csr(CSR_CAUSAL_ENABLE, (ph >= 6) ? 11'd1 : 11'd0);
         random_phase(160);
      end

      if (errors == 0)
         $display("tb_causal_tile_partial_sum_reduce_top: done, clean");
      else
         $display("tb_causal_tile_partial_sum_reduce_top: done, errors");
      $finish;
   end

   initial begin
      #(12 * 600000);
      $display("tb_causal_tile_partial_sum_reduce_top: done, errors");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/ctpsr_pkg.sv
rtl/ctpsr_front.sv
rtl/ctpsr_queue.sv
rtl/ctpsr_back.sv
rtl/causal_tile_partial_sum_reduce_top.sv
tb/tb_causal_tile_partial_sum_reduce_top.sv
